// ===== hdl/d2e_pkg.sv =====
// shared types, constants and month table for the date to epoch seconds converter
package d2e_pkg;

    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int ZONE_W   = 5;
    localparam int SECS_W   = 33;

    localparam int IN_BITS  = YEAR_W + MONTH_W + DAY_W + HOUR_W + MINUTE_W + SECOND_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_W    = ((SECS_W + 7) / 8) * 8;

    localparam int YOFF_W   = 8;
    localparam int MDAYS_W  = 9;
    localparam int HZ_W     = 7;
    localparam int DAYS_W   = 17;
    localparam int TOD_W    = 19;

    localparam logic [YEAR_W-1:0] PIVOT_YEAR    = YEAR_W'(69);
    localparam logic [YEAR_W-1:0] CENTURY_BASE  = YEAR_W'(2000);
    localparam logic [YEAR_W-1:0] EPOCH_YEAR    = YEAR_W'(1970);
    localparam logic [YEAR_W-1:0] LAST_YEAR     = YEAR_W'(2099);
    localparam logic [DAYS_W-1:0] DAYS_PER_YEAR = DAYS_W'(365);
    localparam logic [TOD_W-1:0]  SECS_PER_HOUR = TOD_W'(3600);
    localparam logic [TOD_W-1:0]  SECS_PER_MIN  = TOD_W'(60);
    localparam logic [SECS_W-1:0] SECS_PER_DAY  = SECS_W'(86400);

    typedef struct packed {
        logic                     invalid;
        logic [YOFF_W-1:0]        year_off;
        logic [MDAYS_W-1:0]       month_days;
        logic [DAY_W-1:0]         day;
        logic signed [HZ_W-1:0]   hour_zone;
        logic [MINUTE_W-1:0]      minute;
        logic [SECOND_W-1:0]      second;
    } t_date_s1;

    // days before the first of each month in a common year, december for 11..15
    function automatic logic [MDAYS_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [MDAYS_W-1:0] d;
        case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            default: d = 9'd334;
        endcase
        return d;
    endfunction

endpackage

// ===== hdl/d2e_date_stage.sv =====
// first pipeline stage: year folding, range check, month offset and zone-corrected hour
module d2e_date_stage
    import d2e_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [YEAR_W-1:0]        i_year,
    input  logic [MONTH_W-1:0]       i_month,
    input  logic [DAY_W-1:0]         i_day,
    input  logic [HOUR_W-1:0]        i_hour,
    input  logic [MINUTE_W-1:0]      i_minute,
    input  logic [SECOND_W-1:0]      i_second,
    input  logic signed [ZONE_W-1:0] i_zone,
    output logic                     o_valid,
    output t_date_s1                 o_s1
);

    logic            r_valid;
    t_date_s1        r_s1;
    t_date_s1        n_s1;
    logic [YEAR_W-1:0] year_full;
    logic [YEAR_W-1:0] year_diff;
    logic            leap;

    always_comb begin
        year_full = (i_year < PIVOT_YEAR) ? (i_year + CENTURY_BASE) : i_year;
        year_diff = year_full - EPOCH_YEAR;
        // within 1970..2099 only 2000 is a century year, and it is a leap year
        leap      = (year_diff[1:0] == 2'd2);

        n_s1.invalid    = (year_full < EPOCH_YEAR) || (year_full > LAST_YEAR);
        n_s1.year_off   = year_diff[YOFF_W-1:0];
        n_s1.month_days = days_before_month(i_month)
                        + MDAYS_W'((i_month > 4'd1) && leap);
        n_s1.day        = i_day;
        n_s1.hour_zone  = $signed({2'b00, i_hour})
                        - $signed({{(HZ_W-ZONE_W){i_zone[ZONE_W-1]}}, i_zone});
        n_s1.minute     = i_minute;
        n_s1.second     = i_second;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_valid = r_valid;
    assign o_s1    = r_s1;

endmodule

// ===== hdl/date_to_epoch_seconds.sv =====
// date to epoch seconds converter top level: zone register, pipeline and stream handshake
// Converts a broken-down Gregorian date and time (years 1970..2099, or 0..68 for
// 2000..2068) into signed seconds since 1970-01-01 00:00:00 minus the zone register
// in whole hours. Four register stages (date decode, day count and time of day,
// day-to-second multiply, final add into the output register) take one transaction
// per clock cycle while the output is not stalled. Each stage holds while its
// successor is full and stalled, so bubbles are squeezed out under backpressure.
// A year outside the supported ranges returns zero seconds with the tuser flag
// set. The zone register should be written only while the pipeline is empty.
module date_to_epoch_seconds
    import d2e_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ZONE_W-1:0] i_cfg_wdata,     // zone_hours, signed
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // year_value[11:0] month_index[15:12] day_of_month[20:16] hour_value[25:21]
    // minute_value[31:26] second_value[37:32], zero fill above
    input  logic [IN_W-1:0]   i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [OUT_W-1:0]  o_m_axis_tdata,  // epoch_seconds[32:0] signed, zero fill above
    output logic [0:0]        o_m_axis_tuser   // year_invalid
);

    localparam int MON_LO = YEAR_W;
    localparam int DAY_LO = MON_LO + MONTH_W;
    localparam int HR_LO  = DAY_LO + DAY_W;
    localparam int MIN_LO = HR_LO + HOUR_W;
    localparam int SEC_LO = MIN_LO + MINUTE_W;

    logic signed [ZONE_W-1:0] r_zone;

    logic     en1, en2, en3, en4;
    logic     v1;
    t_date_s1 s1;

    logic                     r_v2;
    logic                     r_inv2;
    logic signed [DAYS_W-1:0] r_days;
    logic signed [TOD_W-1:0]  r_tod2;
    logic signed [DAYS_W-1:0] n_days;
    logic signed [TOD_W-1:0]  n_tod;

    logic                     r_v3;
    logic                     r_inv3;
    logic signed [SECS_W-1:0] r_prod;
    logic signed [TOD_W-1:0]  r_tod3;
    logic signed [SECS_W-1:0] n_prod;

    logic                     r_v4;
    logic                     r_inv4;
    logic signed [SECS_W-1:0] r_secs;
    logic signed [SECS_W-1:0] n_secs;

    logic [YOFF_W:0]          yoff_p1;
    logic [DAYS_W-1:0]        days_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= '0;
        end else if (i_cfg_we) begin
            r_zone <= i_cfg_wdata;
        end
    end

    // per-stage advance: a stage moves when empty or when the next one moves
    assign en4 = !r_v4 || i_m_axis_tready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !v1 || en2;
    assign o_s_axis_tready = en1;

    d2e_date_stage u_date_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en1),
        .i_valid  (i_s_axis_tvalid),
        .i_year   (i_s_axis_tdata[MON_LO-1:0]),
        .i_month  (i_s_axis_tdata[DAY_LO-1:MON_LO]),
        .i_day    (i_s_axis_tdata[HR_LO-1:DAY_LO]),
        .i_hour   (i_s_axis_tdata[MIN_LO-1:HR_LO]),
        .i_minute (i_s_axis_tdata[SEC_LO-1:MIN_LO]),
        .i_second (i_s_axis_tdata[SEC_LO+SECOND_W-1:SEC_LO]),
        .i_zone   (r_zone),
        .o_valid  (v1),
        .o_s1     (s1)
    );

    // stage 2: day count and time of day
    always_comb begin
        yoff_p1  = {1'b0, s1.year_off} + 9'd1;
        days_pos = DAYS_W'(s1.year_off) * DAYS_PER_YEAR
                 + DAYS_W'(yoff_p1 >> 2)
                 + DAYS_W'(s1.month_days)
                 + DAYS_W'(s1.day);
        n_days   = $signed(days_pos - DAYS_W'(1));
        n_tod    = $signed({{(TOD_W-HZ_W){s1.hour_zone[HZ_W-1]}}, s1.hour_zone} * SECS_PER_HOUR
                 + TOD_W'(s1.minute) * SECS_PER_MIN
                 + TOD_W'(s1.second));
    end

    // stage 3: days to seconds
    assign n_prod = $signed({{(SECS_W-DAYS_W){r_days[DAYS_W-1]}}, r_days} * SECS_PER_DAY);

    // stage 4: final sum
    assign n_secs = r_inv3 ? '0
                  : r_prod + $signed({{(SECS_W-TOD_W){r_tod3[TOD_W-1]}}, r_tod3});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en2) begin
                r_v2 <= v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_inv2 <= s1.invalid;
            r_days <= n_days;
            r_tod2 <= n_tod;
        end
        if (en3) begin
            r_inv3 <= r_inv2;
            r_prod <= n_prod;
            r_tod3 <= r_tod2;
        end
        if (en4) begin
            r_inv4 <= r_inv3;
            r_secs <= n_secs;
        end
    end

    assign o_m_axis_tvalid = r_v4;
    assign o_m_axis_tdata  = {{(OUT_W-SECS_W){1'b0}}, r_secs};
    assign o_m_axis_tuser  = r_inv4;

endmodule
